[design/priority_rr_credit_scheduler_unit_defines.svh]
// Assertion macros for the priority round-robin credit scheduler.
// Expects signals clk and rst_n in the including scope; no other dependencies.
`ifndef PRIORITY_RR_CREDIT_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_RR_CREDIT_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRRCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRRCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/prrcs_pkg.sv]
// Shared types, constants and control/status bundles of the scheduler.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package prrcs_pkg;

  // Parameter defaults
  localparam int MAX_QUEUES_DEF = 64;
  localparam int TIME_BITS_DEF  = 48;

  // Fixed field widths
  localparam int ACTIVE_W   = 7;
  localparam int BYTES_W    = 16;
  localparam int RATE_W     = 32;
  localparam int TOK_W      = 32;
  localparam int FTIME_W    = 48;
  localparam int QIDX_W     = 6;
  localparam int GRANT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Refill multiply is split into two partial products of this many bits
  localparam int MUL_PART_W = 24;
  localparam int FRAC_BITS  = 16;
  localparam logic [TOK_W-1:0] TOK_SAT = 32'hffffffff;

  // Register reset values
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST  = 7'd1;
  localparam logic [BYTES_W-1:0]  BYTES_RST   = 16'd84;
  localparam logic [RATE_W-1:0]   RATE_RST    = 32'd65536;
  localparam logic [TOK_W-1:0]    MAX_TOK_RST = 32'd65535;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOK = 2'd3;

  typedef enum logic [GRANT_W-1:0] {
    GRANT_NONE    = 3'd0,
    GRANT_ACK     = 3'd1,
    GRANT_DATA    = 3'd2,
    GRANT_CREDIT  = 3'd3,
    GRANT_BLOCKED = 3'd4
  } grant_t;

  typedef struct packed {
    logic   clr_wr;
    logic   cap_item;
    logic   store_wr;
    logic   scan_init;
    logic   mod_step;
    logic   scan_en;
    logic   ref_sub;
    logic   mul_lo;
    logic   mul_hi;
    logic   ref_sum;
    logic   ref_add;
    logic   charge;
    logic   set_res;
    grant_t res_grant;
    logic   res_wake;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_sched;
    logic ack;
    logic data;
    logic mod_done;
    logic scan_found;
    logic scan_done;
    logic tokens_ok;
    logic out_free;
  } status_t;

endpackage

[design/prrcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module prrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/prrcs_ctrl.sv]
// Sequencing state machine of the scheduler.
// Depends on prrcs_pkg; drives the datapath through cmd_t, reads status_t.
`timescale 1ns / 1ps

module prrcs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prrcs_pkg::status_t st,
  output prrcs_pkg::cmd_t    cmd
);

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_DECODE  = 13'b0000000000100,
    S_STORE   = 13'b0000000001000,
    S_MOD     = 13'b0000000010000,
    S_SCAN    = 13'b0000000100000,
    S_REF_SUB = 13'b0000001000000,
    S_MUL_LO  = 13'b0000010000000,
    S_MUL_HI  = 13'b0000100000000,
    S_REF_SUM = 13'b0001000000000,
    S_REF_ADD = 13'b0010000000000,
    S_CHARGE  = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.cap_item = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!st.op_sched) begin
          state_nxt = S_STORE;
        end else if (st.ack) begin
          cmd.set_res   = 1'b1;
          cmd.res_grant = prrcs_pkg::GRANT_ACK;
          state_nxt     = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_STORE: begin
        cmd.store_wr  = 1'b1;
        cmd.set_res   = 1'b1;
        cmd.res_grant = prrcs_pkg::GRANT_NONE;
        state_nxt     = S_DONE;
      end
      S_MOD: begin
        if (st.mod_done) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.scan_found) begin
          state_nxt = S_REF_SUB;
        end else if (st.scan_done) begin
          cmd.set_res   = 1'b1;
          cmd.res_grant = st.data ? prrcs_pkg::GRANT_DATA : prrcs_pkg::GRANT_NONE;
          cmd.res_wake  = !st.data;
          state_nxt     = S_DONE;
        end
      end
      S_REF_SUB: begin
        cmd.ref_sub = 1'b1;
        state_nxt   = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_REF_SUM;
      end
      S_REF_SUM: begin
        cmd.ref_sum = 1'b1;
        state_nxt   = S_REF_ADD;
      end
      S_REF_ADD: begin
        cmd.ref_add = 1'b1;
        state_nxt   = S_CHARGE;
      end
      S_CHARGE: begin
        cmd.charge    = 1'b1;
        cmd.set_res   = 1'b1;
        cmd.res_grant = st.tokens_ok ? prrcs_pkg::GRANT_CREDIT : prrcs_pkg::GRANT_BLOCKED;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/prrcs_dp.sv]
// Datapath: configuration, queue table RAM, scan, token bucket, result word.
// Depends on prrcs_pkg and prrcs_ram; steered by prrcs_ctrl through cmd_t.
`timescale 1ns / 1ps

module prrcs_dp #(
  parameter int MAX_QUEUES = prrcs_pkg::MAX_QUEUES_DEF,
  parameter int TIME_BITS  = prrcs_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  prrcs_pkg::cmd_t                     cmd,
  output prrcs_pkg::status_t                  st,
  input  logic                                cfg_we,
  input  logic [prrcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prrcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_op,
  input  logic [prrcs_pkg::QIDX_W-1:0]        in_queue_index,
  input  logic                                in_finished,
  input  logic [prrcs_pkg::FTIME_W-1:0]       in_next_avail_ns,
  input  logic [prrcs_pkg::FTIME_W-1:0]       in_now_ns,
  input  logic                                in_ack_pending,
  input  logic                                in_data_pending,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [prrcs_pkg::GRANT_W-1:0]       out_grant,
  output logic [prrcs_pkg::QIDX_W-1:0]        out_granted_queue,
  output logic [prrcs_pkg::TOK_W-1:0]         out_tokens_left,
  output logic                                out_wake_valid,
  output logic [prrcs_pkg::FTIME_W-1:0]       out_wake_ns
);

  localparam int QW = $clog2(MAX_QUEUES);
  localparam int NW = $clog2(MAX_QUEUES + 1);
  localparam int EW = QW + 7;
  localparam int TB = TIME_BITS;
  localparam int PW = prrcs_pkg::MUL_PART_W;
  localparam int RW = prrcs_pkg::RATE_W;
  localparam int MW = PW + RW;
  localparam int SW = 2 * PW + RW;
  localparam int FB = prrcs_pkg::FRAC_BITS;
  localparam int KW = prrcs_pkg::TOK_W;

  // Configuration
  logic [prrcs_pkg::ACTIVE_W-1:0] act_r, act_nxt;
  logic [prrcs_pkg::BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [RW-1:0]                  rate_r, rate_nxt;
  logic [KW-1:0]                  maxt_r, maxt_nxt;

  // Captured item
  logic                           op_r, op_nxt;
  logic [prrcs_pkg::QIDX_W-1:0]   qi_r, qi_nxt;
  logic                           fin_r, fin_nxt;
  logic [TB-1:0]                  nav_r, nav_nxt;
  logic [TB-1:0]                  now_r, now_nxt;
  logic                           ack_r, ack_nxt;
  logic                           data_r, data_nxt;

  // Scan and clearing pass
  logic [QW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [QW-1:0] iss_idx_r, iss_idx_nxt;
  logic [NW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [QW-1:0] rd_idx_r, rd_idx_nxt;
  logic          any_r, any_nxt;
  logic [TB-1:0] min_r, min_nxt;
  logic [QW-1:0] pick_r, pick_nxt;

  // Scheduler state
  logic [QW-1:0] rr_r, rr_nxt;
  logic [KW-1:0] tok_r, tok_nxt;
  logic [TB-1:0] bclk_r, bclk_nxt;

  // Refill pipeline
  logic [TB-1:0] el_r, el_nxt;
  logic          need_r, need_nxt;
  logic [MW-1:0] p_lo_r, p_lo_nxt;
  logic [MW-1:0] p_hi_r, p_hi_nxt;
  logic [KW-1:0] add_r, add_nxt;

  // Result
  prrcs_pkg::grant_t res_grant_r, res_grant_nxt;
  logic              res_wake_r, res_wake_nxt;
  logic                          out_valid_r, out_valid_nxt;
  prrcs_pkg::grant_t             out_grant_r, out_grant_nxt;
  logic [prrcs_pkg::QIDX_W-1:0]  out_gq_r, out_gq_nxt;
  logic [KW-1:0]                 out_tok_r, out_tok_nxt;
  logic                          out_wv_r, out_wv_nxt;
  logic [prrcs_pkg::FTIME_W-1:0] out_wns_r, out_wns_nxt;

  // RAM ports and helpers
  logic          ram_we, ram_re;
  logic [QW-1:0] ram_waddr;
  logic [TB:0]   ram_wdata, ram_rdata;
  logic          rd_fin;
  logic [TB-1:0] rd_nav;
  logic          qi_ok, issue, evalu, hit, wake_ok;
  logic [63:0]   el64;
  logic [SW-1:0] sum;
  logic [KW:0]   tok_sum;

  assign rd_fin = ram_rdata[TB];
  assign rd_nav = ram_rdata[TB-1:0];
  assign qi_ok  = EW'(qi_r) < EW'(MAX_QUEUES);
  assign issue  = cmd.scan_en && (iss_cnt_r != n_r);
  assign evalu  = cmd.scan_en && rd_vld_r && !rd_fin;
  assign hit    = evalu && (rd_nav <= now_r);
  assign el64   = 64'(el_r);
  assign sum    = SW'(p_lo_r) + {p_hi_r, {PW{1'b0}}};
  assign tok_sum = {1'b0, tok_r} + {1'b0, add_r};
  assign wake_ok = res_wake_r && any_r && (min_r > now_r);

  // Table RAM: finished flag on top of the next-available time
  assign ram_we    = cmd.clr_wr || (cmd.store_wr && qi_ok);
  assign ram_waddr = cmd.clr_wr ? clr_r : QW'(qi_r);
  assign ram_wdata = cmd.clr_wr ? {1'b1, {TB{1'b0}}} : {fin_r, nav_r};
  assign ram_re    = issue;

  prrcs_ram #(
    .WIDTH (TB + 1),
    .DEPTH (MAX_QUEUES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss_idx_r),
    .rdata (ram_rdata)
  );

  // Configuration writes
  always_comb begin
    act_nxt   = act_r;
    bytes_nxt = bytes_r;
    rate_nxt  = rate_r;
    maxt_nxt  = maxt_r;
    if (cfg_we) begin
      case (cfg_index)
        prrcs_pkg::CFG_ACTIVE:  act_nxt   = cfg_wdata[prrcs_pkg::ACTIVE_W-1:0];
        prrcs_pkg::CFG_BYTES:   bytes_nxt = cfg_wdata[prrcs_pkg::BYTES_W-1:0];
        prrcs_pkg::CFG_RATE:    rate_nxt  = cfg_wdata[RW-1:0];
        prrcs_pkg::CFG_MAX_TOK: maxt_nxt  = cfg_wdata[KW-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_comb begin
    op_nxt   = op_r;
    qi_nxt   = qi_r;
    fin_nxt  = fin_r;
    nav_nxt  = nav_r;
    now_nxt  = now_r;
    ack_nxt  = ack_r;
    data_nxt = data_r;
    if (cmd.cap_item) begin
      op_nxt   = in_op;
      qi_nxt   = in_queue_index;
      fin_nxt  = in_finished;
      nav_nxt  = TB'(in_next_avail_ns);
      now_nxt  = TB'(in_now_ns);
      ack_nxt  = in_ack_pending;
      data_nxt = in_data_pending;
    end
  end

  // Clearing pass, start reduction and scan
  always_comb begin
    clr_nxt     = cmd.clr_wr ? clr_r + 1'b1 : clr_r;
    n_nxt       = n_r;
    iss_idx_nxt = iss_idx_r;
    iss_cnt_nxt = iss_cnt_r;
    rd_vld_nxt  = issue;
    rd_idx_nxt  = issue ? iss_idx_r : rd_idx_r;
    any_nxt     = any_r;
    min_nxt     = min_r;
    pick_nxt    = hit ? rd_idx_r : pick_r;
    if (cmd.scan_init) begin
      n_nxt       = (EW'(act_r) < EW'(MAX_QUEUES)) ? NW'(act_r) : NW'(MAX_QUEUES);
      iss_idx_nxt = rr_r;
      iss_cnt_nxt = '0;
      any_nxt     = 1'b0;
    end else if (cmd.mod_step) begin
      iss_idx_nxt = QW'(EW'(iss_idx_r) - EW'(n_r));
    end else if (issue) begin
      iss_cnt_nxt = iss_cnt_r + 1'b1;
      iss_idx_nxt = (EW'(iss_idx_r) + 1'b1 == EW'(n_r)) ? '0 : iss_idx_r + 1'b1;
    end
    // Earliest time among unfinished entries, for the wake-up report
    if (evalu && (!any_r || rd_nav < min_r)) begin
      any_nxt = 1'b1;
      min_nxt = rd_nav;
    end
  end

  // Token bucket
  always_comb begin
    el_nxt   = cmd.ref_sub ? now_r - bclk_r : el_r;
    need_nxt = cmd.ref_sub ? (now_r > bclk_r) : need_r;
    p_lo_nxt = cmd.mul_lo ? el64[PW-1:0] * rate_r : p_lo_r;
    p_hi_nxt = cmd.mul_hi ? el64[2*PW-1:PW] * rate_r : p_hi_r;
    add_nxt  = add_r;
    if (cmd.ref_sum) begin
      if (((|el64[63:2*PW]) && (rate_r != '0)) || (|sum[SW-1:KW+FB])) begin
        add_nxt = prrcs_pkg::TOK_SAT;
      end else begin
        add_nxt = sum[KW+FB-1:FB];
      end
    end
    tok_nxt  = tok_r;
    bclk_nxt = bclk_r;
    rr_nxt   = rr_r;
    if (cmd.ref_add && need_r) begin
      tok_nxt  = (tok_sum < {1'b0, maxt_r}) ? tok_sum[KW-1:0] : maxt_r;
      bclk_nxt = now_r;
    end else if (cmd.charge && st.tokens_ok) begin
      tok_nxt = tok_r - KW'(bytes_r);
      rr_nxt  = pick_r;
    end
  end

  // Result word
  always_comb begin
    res_grant_nxt = cmd.set_res ? cmd.res_grant : res_grant_r;
    res_wake_nxt  = cmd.set_res ? cmd.res_wake : res_wake_r;
    out_grant_nxt = out_grant_r;
    out_gq_nxt    = out_gq_r;
    out_tok_nxt   = out_tok_r;
    out_wv_nxt    = out_wv_r;
    out_wns_nxt   = out_wns_r;
    if (cmd.out_load) begin
      out_grant_nxt = res_grant_r;
      out_gq_nxt    = (res_grant_r == prrcs_pkg::GRANT_CREDIT ||
                       res_grant_r == prrcs_pkg::GRANT_BLOCKED) ?
                      prrcs_pkg::QIDX_W'(pick_r) : '0;
      out_tok_nxt   = tok_r;
      out_wv_nxt    = wake_ok;
      out_wns_nxt   = wake_ok ? prrcs_pkg::FTIME_W'(min_r) : '0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Status back to the controller
  always_comb begin
    st            = '0;
    st.clr_last   = EW'(clr_r) == EW'(MAX_QUEUES - 1);
    st.op_sched   = op_r;
    st.ack        = ack_r;
    st.data       = data_r;
    st.mod_done   = (n_r == '0) || (EW'(iss_idx_r) < EW'(n_r));
    st.scan_found = hit;
    st.scan_done  = (iss_cnt_r == n_r) && !rd_vld_r;
    st.tokens_ok  = tok_r >= KW'(bytes_r);
    st.out_free   = !out_valid_r || out_ready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= prrcs_pkg::ACTIVE_RST;
      bytes_r     <= prrcs_pkg::BYTES_RST;
      rate_r      <= prrcs_pkg::RATE_RST;
      maxt_r      <= prrcs_pkg::MAX_TOK_RST;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      rr_r        <= '0;
      tok_r       <= '0;
      bclk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      bytes_r     <= bytes_nxt;
      rate_r      <= rate_nxt;
      maxt_r      <= maxt_nxt;
      clr_r       <= clr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rr_r        <= rr_nxt;
      tok_r       <= tok_nxt;
      bclk_r      <= bclk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    qi_r        <= qi_nxt;
    fin_r       <= fin_nxt;
    nav_r       <= nav_nxt;
    now_r       <= now_nxt;
    ack_r       <= ack_nxt;
    data_r      <= data_nxt;
    n_r         <= n_nxt;
    iss_idx_r   <= iss_idx_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    any_r       <= any_nxt;
    min_r       <= min_nxt;
    pick_r      <= pick_nxt;
    el_r        <= el_nxt;
    need_r      <= need_nxt;
    p_lo_r      <= p_lo_nxt;
    p_hi_r      <= p_hi_nxt;
    add_r       <= add_nxt;
    res_grant_r <= res_grant_nxt;
    res_wake_r  <= res_wake_nxt;
    out_grant_r <= out_grant_nxt;
    out_gq_r    <= out_gq_nxt;
    out_tok_r   <= out_tok_nxt;
    out_wv_r    <= out_wv_nxt;
    out_wns_r   <= out_wns_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_grant         = out_grant_r;
  assign out_granted_queue = out_gq_r;
  assign out_tokens_left   = out_tok_r;
  assign out_wake_valid    = out_wv_r;
  assign out_wake_ns       = out_wns_r;

endmodule

[design/priority_rr_credit_scheduler_unit.sv]
// Egress scheduler: strict priority, round-robin credit queues, token bucket.
// Top level: instantiates prrcs_ctrl and prrcs_dp; uses prrcs_pkg and the defines header.
//
// One word in, one result word out. A store word writes one credit queue's
// finished flag and next-available time; a schedule word picks ACK, a credit
// queue (gated by the token bucket) or data, or reports a wake-up time.
// Items are worked one at a time. A store word passes through decode and
// the table write; a schedule word with a pending ACK goes from decode
// straight to the result. Otherwise the scan reads the queue table RAM one
// entry per cycle through its single read port, after decode and a
// start-pointer reduction (one subtraction of the active count per step
// while the round-robin pointer lies at or beyond it), and stops at the
// first eligible entry or after a full pass over the active queues.
// A found queue then goes through refill (elapsed time, two 24x32 partial
// products, sum, add) and the charge. The result is then loaded into the
// output register once it is free, and the block returns to idle to take
// the next word. The output register lets the next word be taken while
// a result still waits; a finished result is held until it has been taken.
// After reset a clearing pass over all MAX_QUEUES entries marks every queue
// finished; no word is taken meanwhile, configuration writes are.
// Configuration is meant to be written only while idle.
`timescale 1ns / 1ps
`include "priority_rr_credit_scheduler_unit_defines.svh"

module priority_rr_credit_scheduler_unit #(
  parameter int MAX_QUEUES = prrcs_pkg::MAX_QUEUES_DEF,
  parameter int TIME_BITS  = prrcs_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [prrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prrcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [prrcs_pkg::QIDX_W-1:0]     in_queue_index,
  input  logic                             in_finished,
  input  logic [prrcs_pkg::FTIME_W-1:0]    in_next_avail_ns,
  input  logic [prrcs_pkg::FTIME_W-1:0]    in_now_ns,
  input  logic                             in_ack_pending,
  input  logic                             in_data_pending,
  // result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [prrcs_pkg::GRANT_W-1:0]    out_grant,
  output logic [prrcs_pkg::QIDX_W-1:0]     out_granted_queue,
  output logic [prrcs_pkg::TOK_W-1:0]      out_tokens_left,
  output logic                             out_wake_valid,
  output logic [prrcs_pkg::FTIME_W-1:0]    out_wake_ns
);

  prrcs_pkg::cmd_t    cmd;
  prrcs_pkg::status_t st;

  // Controller: sequences store, scan, refill and charge, and hands the
  // finished word to the output register
  prrcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: registers, queue table, round-robin scan, bucket arithmetic
  prrcs_dp #(
    .MAX_QUEUES (MAX_QUEUES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_queue_index    (in_queue_index),
    .in_finished       (in_finished),
    .in_next_avail_ns  (in_next_avail_ns),
    .in_now_ns         (in_now_ns),
    .in_ack_pending    (in_ack_pending),
    .in_data_pending   (in_data_pending),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_grant         (out_grant),
    .out_granted_queue (out_granted_queue),
    .out_tokens_left   (out_tokens_left),
    .out_wake_valid    (out_wake_valid),
    .out_wake_ns       (out_wake_ns)
  );

  // One word at a time: taking a word closes the input until it is done
  `PRRCS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "word taken while busy")
  // Never overwrite a result that has not been taken
  `PRRCS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  // A wake-up time goes only with an empty grant
  `PRRCS_ASSERT_IMP(a_wake_idle, out_valid && out_wake_valid,
                    out_grant == prrcs_pkg::GRANT_NONE, "wake-up time with a grant")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the priority round-robin credit scheduler.
// Depends on prrcs_pkg and priority_rr_credit_scheduler_unit; reads no files.
`timescale 1ns / 1ps

module testbench;
  import prrcs_pkg::*;

  localparam int          QUEUES      = MAX_QUEUES_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic        OP_STORE    = 1'b0;
  localparam logic        OP_SCHED    = 1'b1;
  localparam logic [FTIME_W-1:0] TIME_TOP = '1;

  // one input word, one field per port
  typedef struct packed {
    logic               op;
    logic [QIDX_W-1:0]  qi;
    logic               fin;
    logic [FTIME_W-1:0] next;
    logic [FTIME_W-1:0] now;
    logic               ack;
    logic               data;
  } word_t;

  // one result word
  typedef struct packed {
    grant_t             grant;
    logic [QIDX_W-1:0]  gq;
    logic [TOK_W-1:0]   tok;
    logic               wv;
    logic [FTIME_W-1:0] wns;
  } result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // one row of the directed table: a word to send or a register to write
  typedef struct {
    row_kind_t             kind;
    word_t                 w;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    result_t               want;
  } row_t;

  // clock, reset and every block input known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_op = 1'b0;
  logic [QIDX_W-1:0]     in_queue_index = '0;
  logic                  in_finished = 1'b0;
  logic [FTIME_W-1:0]    in_next_avail_ns = '0;
  logic [FTIME_W-1:0]    in_now_ns = '0;
  logic                  in_ack_pending = 1'b0;
  logic                  in_data_pending = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [GRANT_W-1:0]    out_grant;
  logic [QIDX_W-1:0]     out_granted_queue;
  logic [TOK_W-1:0]      out_tokens_left;
  logic                  out_wake_valid;
  logic [FTIME_W-1:0]    out_wake_ns;

  // scheduler image kept alongside the block
  logic [ACTIVE_W-1:0] cfg_active;
  logic [BYTES_W-1:0]  cfg_bytes;
  logic [RATE_W-1:0]   cfg_rate;
  logic [TOK_W-1:0]    cfg_max_tok;
  logic                q_done     [QUEUES];
  logic [FTIME_W-1:0]  q_ready_at [QUEUES];
  logic [QIDX_W-1:0]   last_served;
  logic [TOK_W-1:0]    bucket;
  logic [FTIME_W-1:0]  bucket_stamp;

  result_t           owed [$];       // results still to come, oldest first
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  logic [FTIME_W-1:0] clock_ns = 48'd10000;
  int                phase_len [8] = '{200, 180, 200, 100, 200, 80, 240, 250};

  priority_rr_credit_scheduler_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_queue_index   (in_queue_index),
    .in_finished      (in_finished),
    .in_next_avail_ns (in_next_avail_ns),
    .in_now_ns        (in_now_ns),
    .in_ack_pending   (in_ack_pending),
    .in_data_pending  (in_data_pending),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_grant        (out_grant),
    .out_granted_queue(out_granted_queue),
    .out_tokens_left  (out_tokens_left),
    .out_wake_valid   (out_wake_valid),
    .out_wake_ns      (out_wake_ns)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up on a hung run; the bound is far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, one decision per cycle on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Scheduler image
  // ---------------------------------------------------------------------

  function automatic void clear_model();
    cfg_active  = ACTIVE_RST;
    cfg_bytes   = BYTES_RST;
    cfg_rate    = RATE_RST;
    cfg_max_tok = MAX_TOK_RST;
    for (int q = 0; q < QUEUES; q++) begin
      q_done[q]     = 1'b1;
      q_ready_at[q] = '0;
    end
    last_served  = '0;
    bucket       = '0;
    bucket_stamp = '0;
  endfunction

  // Refill only when time has moved on; saturate the gain at 32 bits, then
  // clamp to the capacity, which also trims a count above a lowered capacity.
  function automatic void top_up_bucket(logic [FTIME_W-1:0] now);
    logic [FTIME_W-1:0] elapsed;
    logic [65:0]        gain;
    if (now <= bucket_stamp) return;
    elapsed = now - bucket_stamp;
    gain = 66'(elapsed) * 66'(cfg_rate[31:16])
         + ((66'(elapsed) * 66'(cfg_rate[15:0])) >> FRAC_BITS);
    if (gain > 66'(TOK_SAT)) gain = 66'(TOK_SAT);
    gain = gain + 66'(bucket);
    bucket = (gain < 66'(cfg_max_tok)) ? gain[TOK_W-1:0] : cfg_max_tok;
    bucket_stamp = now;
  endfunction

  // Work out the result of one accepted word and advance the image.
  function automatic result_t predict_word(word_t w);
    result_t            r;
    int                 span, k, pick;
    logic               hit, seen;
    logic [FTIME_W-1:0] soonest;
    r = '0;
    r.grant = GRANT_NONE;
    if (w.op == OP_STORE) begin
      q_done[w.qi]     = w.fin;
      q_ready_at[w.qi] = w.next;
    end else if (w.ack) begin
      r.grant = GRANT_ACK;
    end else begin
      span = (cfg_active > QUEUES) ? QUEUES : int'(cfg_active);
      hit  = 1'b0;
      pick = 0;
      // round-robin from the last served queue, wrapping a stale pointer
      for (k = 0; k < span && !hit; k++) begin
        pick = (k + int'(last_served)) % span;
        if (!q_done[pick] && q_ready_at[pick] <= w.now) hit = 1'b1;
      end
      if (hit) begin
        top_up_bucket(w.now);
        r.gq = pick[QIDX_W-1:0];
        if (bucket >= TOK_W'(cfg_bytes)) begin
          bucket      = bucket - TOK_W'(cfg_bytes);
          last_served = pick[QIDX_W-1:0];
          r.grant     = GRANT_CREDIT;
        end else begin
          // tokens short: hold everything, and the data queue waits too
          r.grant = GRANT_BLOCKED;
        end
      end else if (w.data) begin
        r.grant = GRANT_DATA;
      end else begin
        seen    = 1'b0;
        soonest = '0;
        for (k = 0; k < span; k++) begin
          if (!q_done[k] && (!seen || q_ready_at[k] < soonest)) begin
            soonest = q_ready_at[k];
            seen    = 1'b1;
          end
        end
        if (seen && soonest > w.now) begin
          r.wv  = 1'b1;
          r.wns = soonest;
        end
      end
    end
    r.tok = bucket;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offer one word after a random gap, hold it until taken, then book its
  // result. Returns just after the accepting edge with valid still high.
  task automatic send_word(word_t w, bit typed, result_t want);
    result_t calc;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= w.op;
    in_queue_index   <= w.qi;
    in_finished      <= w.fin;
    in_next_avail_ns <= w.next;
    in_now_ns        <= w.now;
    in_ack_pending   <= w.ack;
    in_data_pending  <= w.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = predict_word(w);
    owed.push_back(typed ? want : calc);
  endtask

  // Drop valid and wait until every booked result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE:  cfg_active  = val[ACTIVE_W-1:0];
      CFG_BYTES:   cfg_bytes   = val[BYTES_W-1:0];
      CFG_RATE:    cfg_rate    = val[RATE_W-1:0];
      CFG_MAX_TOK: cfg_max_tok = val[TOK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
               cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Checking: every taken result against the oldest booked one
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (owed.size() == 0) begin
        report_mismatch("result with none owed, grant", 64'(out_grant), 64'(0));
      end else begin
        due = owed.pop_front();
        if (out_grant !== due.grant)
          report_mismatch("grant", 64'(out_grant), 64'(due.grant));
        if (out_granted_queue !== due.gq)
          report_mismatch("granted_queue", 64'(out_granted_queue), 64'(due.gq));
        if (out_tokens_left !== due.tok)
          report_mismatch("tokens_left", 64'(out_tokens_left), 64'(due.tok));
        if (out_wake_valid !== due.wv)
          report_mismatch("wake_valid", 64'(out_wake_valid), 64'(due.wv));
        if (out_wake_ns !== due.wns)
          report_mismatch("wake_ns", 64'(out_wake_ns), 64'(due.wns));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic row_t store_row(int qi, bit fin, logic [FTIME_W-1:0] next);
    row_t r;
    r = '{kind: ROW_WORD, w: '0, reg_idx: '0, reg_val: '0, typed: 1'b0, want: '0};
    r.w.op   = OP_STORE;
    r.w.qi   = qi[QIDX_W-1:0];
    r.w.fin  = fin;
    r.w.next = next;
    return r;
  endfunction

  function automatic row_t sched_row(logic [FTIME_W-1:0] now, bit ack, bit data);
    row_t r;
    r = '{kind: ROW_WORD, w: '0, reg_idx: '0, reg_val: '0, typed: 1'b0, want: '0};
    r.w.op   = OP_SCHED;
    r.w.now  = now;
    r.w.ack  = ack;
    r.w.data = data;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, w: '0, reg_idx: idx, reg_val: val, typed: 1'b0, want: '0};
    return r;
  endfunction

  // Pin the expected result of a row whose outcome is plain to see.
  function automatic row_t typed_row(row_t r, grant_t g, logic [TOK_W-1:0] tok,
                                     bit wv, logic [FTIME_W-1:0] wns);
    r.typed      = 1'b1;
    r.want       = '0;
    r.want.grant = g;
    r.want.tok   = tok;
    r.want.wv    = wv;
    r.want.wns   = wns;
    return r;
  endfunction

  // Mostly well-formed traffic on a steadily advancing clock; the rest is
  // noise: any op, any queue, far-off times and stale clocks.
  function automatic word_t random_word();
    word_t       w;
    int unsigned span, roll;
    span = (cfg_active > QUEUES) ? QUEUES : 32'(cfg_active);
    if (span == 0) span = QUEUES;
    roll = $urandom_range(99);
    // fields an op ignores still get random values
    w.op   = 1'($urandom_range(1));
    w.qi   = QIDX_W'($urandom_range(QUEUES - 1));
    w.fin  = 1'($urandom_range(1));
    w.next = FTIME_W'({$urandom(), $urandom()});
    w.now  = clock_ns - FTIME_W'($urandom_range(4000));
    w.ack  = 1'($urandom_range(1));
    w.data = 1'($urandom_range(1));
    if (roll < 8) return w;
    if (roll < 40) begin
      w.op = OP_STORE;
      if ($urandom_range(9) != 0) w.qi = QIDX_W'($urandom_range(span - 1));
      w.fin  = ($urandom_range(99) < 20);
      w.next = clock_ns + FTIME_W'($urandom_range(600)) - FTIME_W'(150);
    end else begin
      w.op = OP_SCHED;
      // the odd long jump lets the refill saturate
      if ($urandom_range(49) == 0) clock_ns = clock_ns + FTIME_W'($urandom_range(1 << 20));
      else                         clock_ns = clock_ns + FTIME_W'($urandom_range(120));
      w.now  = clock_ns;
      w.ack  = ($urandom_range(9) == 0);
      w.data = ($urandom_range(99) < 45);
    end
    return w;
  endfunction

  initial begin : main_flow
    row_t                  plan [$];
    logic [CFG_DATA_W-1:0] set_active, set_bytes, set_rate, set_max;
    clear_model();
    send_idle_pct = 26;
    recv_idle_pct = 86;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. After reset every queue is finished and the bucket
    // is empty, so the first rows can be read off directly.
    plan.push_back(typed_row(sched_row(0, 0, 0), GRANT_NONE, 0, 0, 0));
    plan.push_back(typed_row(sched_row(TIME_TOP, 1, 1), GRANT_ACK, 0, 0, 0));
    plan.push_back(typed_row(sched_row(TIME_TOP, 0, 1), GRANT_DATA, 0, 0, 0));
    plan.push_back(typed_row(store_row(0, 0, TIME_TOP), GRANT_NONE, 0, 0, 0));
    plan.push_back(typed_row(sched_row(1000, 0, 0), GRANT_NONE, 0, 1, TIME_TOP));
    plan.push_back(typed_row(store_row(0, 0, 0), GRANT_NONE, 0, 0, 0));
    plan.push_back(sched_row(100, 0, 1));              // first credit grant
    plan.push_back(sched_row(150, 0, 1));              // tokens short, data held
    plan.push_back(cfg_row(CFG_ACTIVE, 127));          // above the queue count
    plan.push_back(store_row(63, 0, 500));
    plan.push_back(store_row(0, 1, 0));
    plan.push_back(sched_row(600, 0, 0));              // last queue served
    plan.push_back(cfg_row(CFG_ACTIVE, 5));            // pointer now stale
    plan.push_back(store_row(2, 0, 0));
    plan.push_back(sched_row(700, 0, 0));
    plan.push_back(cfg_row(CFG_MAX_TOK, 100));         // trim on next refill
    plan.push_back(sched_row(701, 0, 0));
    plan.push_back(cfg_row(CFG_BYTES, 65535));
    plan.push_back(cfg_row(CFG_RATE, 32'hffffffff));
    plan.push_back(cfg_row(CFG_MAX_TOK, 32'hffffffff));
    plan.push_back(sched_row(800, 0, 0));
    plan.push_back(cfg_row(CFG_ACTIVE, 0));            // nothing scanned
    plan.push_back(sched_row(900, 0, 0));
    plan.push_back(sched_row(900, 0, 1));
    plan.push_back(cfg_row(CFG_ACTIVE, 64));
    plan.push_back(cfg_row(CFG_BYTES, 1));
    plan.push_back(cfg_row(CFG_RATE, 0));
    plan.push_back(cfg_row(CFG_MAX_TOK, 0));
    plan.push_back(sched_row(1000, 0, 0));             // empty bucket, no refill

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    // Random part: one register setting per phase, idling pattern by thirds.
    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 86;
      end else if (p < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_active = $urandom_range(64, 1);
      set_bytes  = $urandom_range(300, 20);
      set_rate   = $urandom_range(200000, 8000);
      set_max    = $urandom_range(3000, 0);
      case (p)
        0: begin
          set_active = 4; set_bytes = 84; set_rate = 65536; set_max = 1000;
        end
        1: begin
          set_active = 64; set_bytes = 1; set_rate = '1; set_max = '1;
        end
        3: begin
          set_active = 1; set_bytes = 65535; set_rate = 0; set_max = 0;
        end
        4: set_active = 127;
        5: set_active = 0;
        7: set_active = 64;
        default: ;
      endcase
      drain_results();
      write_reg(CFG_ACTIVE, set_active);
      write_reg(CFG_BYTES, set_bytes);
      write_reg(CFG_RATE, set_rate);
      write_reg(CFG_MAX_TOK, set_max);
      for (int n = 0; n < phase_len[p]; n++) begin
        // now and then hold the sender until the block has run dry
        if ($urandom_range(149) == 0) drain_results();
        send_word(random_word(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
